>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers clocked on i_clk, disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define SSA_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// expression must never be true out of reset
`define SSA_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define SSA_ASSERT(label, prop)
`define SSA_NEVER(label, expr)

`endif

`endif

>>> hw/rtl/ssa_pkg.sv
// ---------------------------------------------------------------------------
// ssa_pkg
// shared constants and types of the spill slot allocator
// ---------------------------------------------------------------------------
`default_nettype none

package ssa_pkg;

    localparam int SLOT_COUNT     = 64;
    localparam int TEMP_COUNT     = 64;
    localparam int BYTES_PER_SLOT = 4;

    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int TEMP_W     = 6;
    localparam int LIVE_W     = 64;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int START_W    = 12;
    localparam int OFS_W      = 13;
    localparam int FRAME_W    = 9;
    localparam int OUT_SLOT_W = 6;
    localparam int SLOT_SHIFT = $clog2(BYTES_PER_SLOT);

    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OWN        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EVICTED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_APPENDED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FIXED      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RESET_DONE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ERROR      = 3'd6;

    // request broadcast to every cell
    typedef struct packed {
        logic [TEMP_W-1:0] temp_id;
        logic [LIVE_W-1:0] live;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  reserved;
    } t_cell_req;

    // owner write into one cell
    typedef struct packed {
        logic              en;
        logic [TEMP_W-1:0] data;
    } t_cell_wr;

    // per cell results back to the control
    typedef struct packed {
        logic              own_pick;
        logic              dead_pick;
        logic              drop;
        logic [TEMP_W-1:0] owner;
    } t_cell_stat;

endpackage

`default_nettype wire

>>> hw/rtl/ssa_cell.sv
// ---------------------------------------------------------------------------
// ssa_cell
// one stack slot: holds its owner temp and joins the two priority chains
// ---------------------------------------------------------------------------
`default_nettype none

module ssa_cell (
    input  wire logic                      i_clk,
    input  wire logic [ssa_pkg::SLOT_W-1:0] i_index,
    input  wire ssa_pkg::t_cell_req        i_req,
    input  wire ssa_pkg::t_cell_wr         i_wr,
    input  wire logic                      i_own_seen,
    output logic                           o_own_seen,
    input  wire logic                      i_dead_seen,
    output logic                           o_dead_seen,
    output ssa_pkg::t_cell_stat            o_stat
);
    import ssa_pkg::*;

    logic [TEMP_W-1:0] r_owner;
    logic [CNT_W-1:0]  w_index;
    logic              w_in_use;
    logic              w_above_res;
    logic              w_own;
    logic              w_dead;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_owner <= i_wr.data;
        end
    end

    assign w_index     = CNT_W'(i_index);
    assign w_in_use    = w_index < i_req.used;
    assign w_above_res = w_index >= i_req.reserved;
    assign w_own       = w_in_use && (r_owner == i_req.temp_id);
    assign w_dead      = w_in_use && w_above_res && !i_req.live[r_owner];

    // own chain runs from the top slot down, dead chain from slot zero up
    assign o_own_seen  = i_own_seen | w_own;
    assign o_dead_seen = i_dead_seen | w_dead;

    assign o_stat.own_pick  = w_own & ~i_own_seen;
    assign o_stat.dead_pick = w_dead & ~i_dead_seen;
    assign o_stat.drop      = w_in_use && w_above_res;
    assign o_stat.owner     = r_owner;

endmodule

`default_nettype wire

>>> hw/rtl/spill_slot_allocator_core.sv
// ---------------------------------------------------------------------------
// spill_slot_allocator_core
// stack slot allocator for spilled temporaries, built as a row of slot cells
// ---------------------------------------------------------------------------
//
// channel  | direction | handshake             | word
// ---------+-----------+-----------------------+---------------------------------
// request  | in        | start & !busy         | i_mode, i_temp_id, i_live_mask
// result   | out       | o_valid, one cycle    | o_slot, o_byte_offset, o_status,
//          |           |                       | o_evicted_valid, o_evicted_temp,
//          |           |                       | o_frame_bytes
// config   | in        | i_cfg_wr_en           | i_cfg_wr_data (start offset)
//
// on accept the word is latched and the block enters S_EVAL, which evaluates
// the cell row; the tables and the result word are registered as it leaves
// S_EVAL, so the result strobe shows when busy is already low again
// the evaluate cycle is set by the priority chains through the slot cells
// synchronous active low reset clears counts, fixed flags and the start offset;
// slot owners are not cleared, only slots below the used count are read
// the receiver cannot stall: each result is shown for exactly one cycle
// ---------------------------------------------------------------------------
`default_nettype none

module spill_slot_allocator_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [ssa_pkg::MODE_W-1:0]          i_mode,
    input  wire logic [ssa_pkg::TEMP_W-1:0]          i_temp_id,
    input  wire logic [ssa_pkg::LIVE_W-1:0]          i_live_mask,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic signed [ssa_pkg::START_W-1:0]  i_cfg_wr_data,
    output logic                                     o_valid,
    output logic [ssa_pkg::OUT_SLOT_W-1:0]           o_slot,
    output logic signed [ssa_pkg::OFS_W-1:0]         o_byte_offset,
    output logic [ssa_pkg::STATUS_W-1:0]             o_status,
    output logic                                     o_evicted_valid,
    output logic [ssa_pkg::TEMP_W-1:0]               o_evicted_temp,
    output logic [ssa_pkg::FRAME_W-1:0]              o_frame_bytes
);
    import ssa_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    t_state r_state;

    // latched request word
    logic [MODE_W-1:0]     r_mode;
    logic [TEMP_W-1:0]     r_temp_id;
    logic [LIVE_W-1:0]     r_live;

    // allocator state
    logic [START_W-1:0]    r_start_offset;
    logic [TEMP_COUNT-1:0] r_fixed;
    logic [CNT_W-1:0]      r_used;
    logic [CNT_W-1:0]      r_reserved;
    logic [CNT_W-1:0]      r_peak;

    // registered result word
    logic                  r_valid;
    logic [SLOT_W-1:0]     r_slot;
    logic [OFS_W-1:0]      r_byte_offset;
    logic [STATUS_W-1:0]   r_status;
    logic                  r_ev_valid;
    logic [TEMP_W-1:0]     r_ev_temp;
    logic [FRAME_W-1:0]    r_frame_bytes;

    // next values
    logic [TEMP_COUNT-1:0] n_fixed;
    logic [CNT_W-1:0]      n_used;
    logic [CNT_W-1:0]      n_reserved;
    logic [CNT_W-1:0]      n_peak;
    logic [SLOT_W-1:0]     n_slot;
    logic [STATUS_W-1:0]   n_status;
    logic                  n_ev_valid;
    logic [TEMP_W-1:0]     n_ev_temp;
    logic [OFS_W-1:0]      n_byte_offset;

    // cell row
    t_cell_req             w_req;
    t_cell_wr              w_wr   [SLOT_COUNT];
    t_cell_stat            w_stat [SLOT_COUNT];
    logic [SLOT_COUNT:0]   w_own_chain;
    logic [SLOT_COUNT:0]   w_dead_chain;

    // gathered from the cells
    logic [SLOT_COUNT-1:0] w_own_pick;
    logic [SLOT_COUNT-1:0] w_dead_pick;
    logic [SLOT_W-1:0]     w_own_idx;
    logic [SLOT_W-1:0]     w_dead_idx;
    logic [TEMP_W-1:0]     w_dead_owner;
    logic [TEMP_COUNT-1:0] w_clear_mask;
    logic                  w_own_any;
    logic                  w_dead_any;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_bad_temp;
    logic [SLOT_W-1:0]     w_app_idx;
    logic                  w_append;
    logic                  w_evict;
    logic [OFS_W-1:0]      w_start_ext;

    assign w_accept   = start && (r_state == S_IDLE);
    assign w_full     = r_used >= CNT_W'(SLOT_COUNT);
    assign w_bad_temp = (TEMP_W + 1)'(r_temp_id) >= (TEMP_W + 1)'(TEMP_COUNT);
    assign w_app_idx  = r_used[SLOT_W-1:0];

    // ------------------------------------------------------------------
    // row of slot cells: the own chain enters at the top slot and the
    // dead chain at slot zero, so the highest own slot and the lowest
    // dead slot win
    // ------------------------------------------------------------------
    assign w_req.temp_id  = r_temp_id;
    assign w_req.live     = r_live;
    assign w_req.used     = r_used;
    assign w_req.reserved = r_reserved;

    assign w_own_chain[SLOT_COUNT] = 1'b0;
    assign w_dead_chain[0]         = 1'b0;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        ssa_cell u_cell (
            .i_clk       (i_clk),
            .i_index     (SLOT_W'(g)),
            .i_req       (w_req),
            .i_wr        (w_wr[g]),
            .i_own_seen  (w_own_chain[g+1]),
            .o_own_seen  (w_own_chain[g]),
            .i_dead_seen (w_dead_chain[g]),
            .o_dead_seen (w_dead_chain[g+1]),
            .o_stat      (w_stat[g])
        );
    end

    assign w_own_any  = w_own_chain[0];
    assign w_dead_any = w_dead_chain[SLOT_COUNT];

    // encode the one hot picks and build the unfix mask for a clear
    always_comb begin
        w_own_idx    = '0;
        w_dead_idx   = '0;
        w_dead_owner = '0;
        w_clear_mask = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_own_pick[i]  = w_stat[i].own_pick;
            w_dead_pick[i] = w_stat[i].dead_pick;
            if (w_stat[i].own_pick) begin
                w_own_idx = w_own_idx | SLOT_W'(i);
            end
            if (w_stat[i].dead_pick) begin
                w_dead_idx   = w_dead_idx | SLOT_W'(i);
                w_dead_owner = w_dead_owner | w_stat[i].owner;
            end
            if (w_stat[i].drop) begin
                w_clear_mask = w_clear_mask
                             | (TEMP_COUNT'(1) << w_stat[i].owner);
            end
        end
    end

    // ------------------------------------------------------------------
    // decision for the latched request
    // ------------------------------------------------------------------
    always_comb begin
        n_fixed    = r_fixed;
        n_used     = r_used;
        n_reserved = r_reserved;
        n_peak     = r_peak;
        n_slot     = '0;
        n_status   = ST_ERROR;
        n_ev_valid = 1'b0;
        n_ev_temp  = '0;
        w_append   = 1'b0;
        w_evict    = 1'b0;

        unique case (r_mode)
            MODE_CLEAR: begin
                // drop every slot above the reserved area
                n_fixed  = r_fixed & ~w_clear_mask;
                n_used   = r_reserved;
                n_status = ST_RESET_DONE;
            end
            MODE_RESERVE: begin
                priority if (w_bad_temp) begin
                    n_status = ST_ERROR;
                end else if (r_fixed[r_temp_id]) begin
                    n_status = ST_FIXED;
                    n_slot   = w_own_any ? w_own_idx : '0;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    // reserved area grows by one and used follows it
                    w_append             = 1'b1;
                    n_fixed[r_temp_id]   = 1'b1;
                    n_reserved           = r_reserved + CNT_W'(1);
                    n_used               = r_reserved + CNT_W'(1);
                    n_slot               = w_app_idx;
                    n_status             = ST_APPENDED;
                end
            end
            MODE_WRITE: begin
                priority if (w_bad_temp || r_fixed[r_temp_id]) begin
                    n_status = ST_ERROR;
                end else if (w_own_any) begin
                    n_fixed[r_temp_id] = 1'b1;
                    n_slot             = w_own_idx;
                    n_status           = ST_OWN;
                end else if (w_dead_any) begin
                    // dead owner loses the slot to the requesting temp
                    w_evict               = 1'b1;
                    n_fixed[w_dead_owner] = 1'b0;
                    n_fixed[r_temp_id]    = 1'b1;
                    n_slot                = w_dead_idx;
                    n_status              = ST_EVICTED;
                    n_ev_valid            = 1'b1;
                    n_ev_temp             = w_dead_owner;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_append           = 1'b1;
                    n_fixed[r_temp_id] = 1'b1;
                    n_used             = r_used + CNT_W'(1);
                    n_slot             = w_app_idx;
                    n_status           = ST_APPENDED;
                end
            end
            default: begin
                n_status = ST_ERROR;
            end
        endcase

        if (n_used > r_peak) begin
            n_peak = n_used;
        end
    end

    // byte offset is start minus four bytes per slot
    assign w_start_ext   = {{(OFS_W - START_W){r_start_offset[START_W-1]}}, r_start_offset};
    assign n_byte_offset = w_start_ext - OFS_W'({n_slot, {SLOT_SHIFT{1'b0}}});

    // owner writes: append at the used count, eviction at the dead pick
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_wr[i].en   = (r_state == S_EVAL)
                         && ((w_append && (w_app_idx == SLOT_W'(i)))
                             || (w_evict && w_dead_pick[i]));
            w_wr[i].data = r_temp_id;
        end
    end

    // ------------------------------------------------------------------
    // state, tables and result word
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_valid        <= 1'b0;
            r_start_offset <= '0;
            r_fixed        <= '0;
            r_used         <= '0;
            r_reserved     <= '0;
            r_peak         <= '0;
        end else begin
            r_valid <= 1'b0;

            if (i_cfg_wr_en) begin
                r_start_offset <= i_cfg_wr_data;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode    <= i_mode;
                        r_temp_id <= i_temp_id;
                        r_live    <= i_live_mask;
                        r_state   <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_fixed       <= n_fixed;
                    r_used        <= n_used;
                    r_reserved    <= n_reserved;
                    r_peak        <= n_peak;
                    r_valid       <= 1'b1;
                    r_slot        <= n_slot;
                    r_byte_offset <= n_byte_offset;
                    r_status      <= n_status;
                    r_ev_valid    <= n_ev_valid;
                    r_ev_temp     <= n_ev_temp;
                    r_frame_bytes <= FRAME_W'({n_peak, {SLOT_SHIFT{1'b0}}});
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state == S_EVAL);
    assign o_valid         = r_valid;
    assign o_slot          = OUT_SLOT_W'(r_slot);
    assign o_byte_offset   = r_byte_offset;
    assign o_status        = r_status;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_temp  = r_ev_temp;
    assign o_frame_bytes   = r_frame_bytes;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    `SSA_ASSERT(a_eval_gives_result, busy |=> o_valid)
    `SSA_ASSERT(a_accept_goes_busy, (start && !busy) |=> busy)
    `SSA_NEVER(a_reserved_above_used, r_reserved > r_used)
    `SSA_NEVER(a_peak_below_used, r_peak < r_used)
    `SSA_ASSERT(a_single_picks, busy |-> ($onehot0(w_own_pick) && $onehot0(w_dead_pick)))
    `SSA_ASSERT(a_evict_status, (o_valid && o_evicted_valid) |-> (o_status == ST_EVICTED))

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for spill_slot_allocator_core: a tracker keeps its own
// slot table, pinned flags and counts, predicts the result word of every
// accepted request and matches it against the result strobe; directed cases
// run first, then random episodes of clear, reserve, write and bad-mode requests
// under several pacing settings and start offsets
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ssa_pkg::*;

    // mode code the block must refuse
    localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;

    localparam int START_MAX = (1 << (START_W - 1)) - 1;
    localparam int START_MIN = -(1 << (START_W - 1));
    localparam int WORDS_PER_PHASE = 360;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_GAP = 60;

    typedef logic [MODE_W-1:0]         t_mode;
    typedef logic [TEMP_W-1:0]         t_temp;
    typedef logic [LIVE_W-1:0]         t_live;
    typedef logic signed [START_W-1:0] t_ofs;

    // one result word as seen on the result ports
    typedef struct packed {
        logic [OUT_SLOT_W-1:0]   slot;
        logic signed [OFS_W-1:0] byte_offset;
        logic [STATUS_W-1:0]     status;
        logic                    ev_valid;
        logic [TEMP_W-1:0]       ev_temp;
        logic [FRAME_W-1:0]      frame_bytes;
    } t_slot_grant;

    // tracks the slot table and predicts every result word
    class slot_alloc_tracker;
        t_temp       owner_tab [SLOT_COUNT];
        bit          pinned [TEMP_COUNT];
        int          used_n;
        int          rsv_n;
        int          peak_n;
        int          start_ofs;
        t_slot_grant pending [$];
        int          errors;
        int          status_seen [8];

        function new();
            foreach (owner_tab[i]) owner_tab[i] = '0;
            foreach (pinned[i]) pinned[i] = 1'b0;
            foreach (status_seen[i]) status_seen[i] = 0;
            used_n = 0;
            rsv_n = 0;
            peak_n = 0;
            start_ofs = 0;
            errors = 0;
        endfunction

        function void set_start(t_ofs v);
            start_ofs = int'(v);
        endfunction

        // works out the word an accepted request must produce
        function void note_request(t_mode mode, t_temp temp, t_live live);
            t_slot_grant g;
            int          i;
            int          pick;
            int          off;
            int          fb;
            bit          done;
            g = '0;
            pick = 0;
            done = 1'b0;
            if (mode == MODE_CLEAR) begin
                for (i = rsv_n; i < used_n; i++) pinned[owner_tab[i]] = 1'b0;
                used_n = rsv_n;
                g.status = ST_RESET_DONE;
            end else if (mode == MODE_RESERVE) begin
                if (pinned[temp]) begin
                    for (i = used_n - 1; i >= 0; i--) begin
                        if (owner_tab[i] == temp) begin
                            pick = i;
                            break;
                        end
                    end
                    g.status = ST_FIXED;
                end else if (used_n >= SLOT_COUNT) begin
                    g.status = ST_FULL;
                end else begin
                    pick = used_n;
                    owner_tab[used_n] = temp;
                    pinned[temp] = 1'b1;
                    rsv_n = rsv_n + 1;
                    used_n = rsv_n;
                    if (peak_n < used_n) peak_n = used_n;
                    g.status = ST_APPENDED;
                end
            end else if (mode == MODE_WRITE) begin
                if (pinned[temp]) begin
                    g.status = ST_ERROR;
                end else begin
                    for (i = used_n - 1; i >= 0; i--) begin
                        if (owner_tab[i] == temp) begin
                            pinned[temp] = 1'b1;
                            pick = i;
                            g.status = ST_OWN;
                            done = 1'b1;
                            break;
                        end
                    end
                    if (!done) begin
                        for (i = rsv_n; i < used_n; i++) begin
                            if (!live[owner_tab[i]]) begin
                                pinned[owner_tab[i]] = 1'b0;
                                g.ev_valid = 1'b1;
                                g.ev_temp = owner_tab[i];
                                owner_tab[i] = temp;
                                pinned[temp] = 1'b1;
                                pick = i;
                                g.status = ST_EVICTED;
                                done = 1'b1;
                                break;
                            end
                        end
                    end
                    if (!done) begin
                        if (used_n >= SLOT_COUNT) begin
                            g.status = ST_FULL;
                        end else begin
                            pick = used_n;
                            owner_tab[used_n] = temp;
                            pinned[temp] = 1'b1;
                            used_n = used_n + 1;
                            if (peak_n < used_n) peak_n = used_n;
                            g.status = ST_APPENDED;
                        end
                    end
                end
            end else begin
                g.status = ST_ERROR;
            end
            off = start_ofs - pick * BYTES_PER_SLOT;
            fb = peak_n * BYTES_PER_SLOT;
            g.slot = pick[OUT_SLOT_W-1:0];
            g.byte_offset = off[OFS_W-1:0];
            g.frame_bytes = fb[FRAME_W-1:0];
            status_seen[g.status]++;
            pending.push_back(g);
        endfunction

        function void check_field(string label, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
                errors++;
            end
        endfunction

        // matches one result word against the oldest prediction
        function void check_result(t_slot_grant got);
            t_slot_grant want;
            if (pending.size() == 0) begin
                $display("%0t: result word with nothing pending, slot %0d status %0d",
                         $time, got.slot, got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            check_field("slot", int'(want.slot), int'(got.slot));
            check_field("byte_offset", int'($signed(want.byte_offset)),
                        int'($signed(got.byte_offset)));
            check_field("status", int'(want.status), int'(got.status));
            check_field("evicted_valid", int'(want.ev_valid), int'(got.ev_valid));
            check_field("evicted_temp", int'(want.ev_temp), int'(got.ev_temp));
            check_field("frame_bytes", int'(want.frame_bytes), int'(got.frame_bytes));
        endfunction
    endclass

    // every input starts at a known value
    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    t_mode i_mode = MODE_CLEAR;
    t_temp i_temp_id = '0;
    t_live i_live_mask = '0;
    logic  i_cfg_wr_en = 1'b0;
    t_ofs  i_cfg_wr_data = '0;

    logic                    busy;
    logic                    o_valid;
    logic [OUT_SLOT_W-1:0]   o_slot;
    logic signed [OFS_W-1:0] o_byte_offset;
    logic [STATUS_W-1:0]     o_status;
    logic                    o_evicted_valid;
    logic [TEMP_W-1:0]       o_evicted_temp;
    logic [FRAME_W-1:0]      o_frame_bytes;

    slot_alloc_tracker tracker;

    // pacing of the request side
    int idle_pct = 0;
    int burst_left = 0;
    int words_sent = 0;
    int offsets_applied = 0;

    spill_slot_allocator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_temp_id       (i_temp_id),
        .i_live_mask     (i_live_mask),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_valid         (o_valid),
        .o_slot          (o_slot),
        .o_byte_offset   (o_byte_offset),
        .o_status        (o_status),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_temp  (o_evicted_temp),
        .o_frame_bytes   (o_frame_bytes)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // result side: the strobe lasts one cycle, sample the pre-edge values
    always @(posedge i_clk) begin
        t_slot_grant seen;
        if (i_rst_n && o_valid) begin
            seen.slot = o_slot;
            seen.byte_offset = o_byte_offset;
            seen.status = o_status;
            seen.ev_valid = o_evicted_valid;
            seen.ev_temp = o_evicted_temp;
            seen.frame_bytes = o_frame_bytes;
            tracker.check_result(seen);
        end
    end

    // idle cycles before the next word, with occasional back-to-back bursts
    function automatic int pick_gap();
        int gap;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 99) < 8) burst_left = $urandom_range(4, 16);
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
        return gap;
    endfunction

    // live masks from all-dead through sparse and dense to all-live
    function automatic t_live rand_live();
        t_live a;
        t_live b;
        a = {$urandom(), $urandom()};
        b = {$urandom(), $urandom()};
        case ($urandom_range(0, 4))
            0: return '1;
            1: return '0;
            2: return a;
            3: return a & b & {$urandom(), $urandom()};
            default: return a | b;
        endcase
    endfunction

    // temps drawn from a narrow window so that they collide often
    function automatic t_temp pool_temp(int base);
        return t_temp'(base + $urandom_range(0, 11));
    endfunction

    // called at a clock edge; returns at the edge that accepted the word
    task automatic send_word(t_mode m, t_temp t, t_live lv);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= m;
        i_temp_id <= t;
        i_live_mask <= lv;
        do @(posedge i_clk); while (busy);
        tracker.note_request(m, t, lv);
        words_sent++;
    endtask

    // let every outstanding result come back, then a little slack
    task automatic drain();
        start <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // start offset may only change while nothing is in flight
    task automatic load_start_offset(t_ofs v);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.set_start(v);
        offsets_applied++;
    endtask

    // one episode of requests; the fill kind writes every free temp in turn
    task automatic run_episode(bit fill_now);
        int kind;
        int n;
        int j;
        int k;
        int tmp;
        int cnt;
        int base;
        int order [TEMP_COUNT];
        t_mode m;
        kind = $urandom_range(0, 99);
        base = $urandom_range(0, 63);
        if (fill_now || kind < 5) begin
            send_word(MODE_CLEAR, pool_temp(base), rand_live());
            cnt = 0;
            for (j = 0; j < TEMP_COUNT; j++) begin
                if (!tracker.pinned[j]) begin
                    order[cnt] = j;
                    cnt++;
                end
            end
            for (j = cnt - 1; j > 0; j--) begin
                k = $urandom_range(0, j);
                tmp = order[j];
                order[j] = order[k];
                order[k] = tmp;
            end
            // everything live, so each one lands on a fresh slot
            for (j = 0; j < cnt; j++) send_word(MODE_WRITE, t_temp'(order[j]), '1);
            // with the frame packed a write is refused and a reserve finds the temp
            send_word(MODE_WRITE, pool_temp(base), '1);
            send_word(MODE_RESERVE, pool_temp(base), rand_live());
        end else if (kind < 75) begin
            // well-formed frame: clear, a few reserves, then a run of writes with the odd reserve
            send_word(MODE_CLEAR, pool_temp(base), rand_live());
            n = $urandom_range(0, 3);
            for (j = 0; j < n; j++) send_word(MODE_RESERVE, pool_temp(base), rand_live());
            n = $urandom_range(4, 24);
            for (j = 0; j < n; j++) begin
                m = ($urandom_range(0, 99) < 10) ? MODE_RESERVE : MODE_WRITE;
                send_word(m, pool_temp(base), rand_live());
            end
        end else begin
            // noise: anything the ports allow, bad mode included
            n = $urandom_range(1, 8);
            for (j = 0; j < n; j++) begin
                send_word(t_mode'($urandom_range(0, 3)), t_temp'($urandom_range(0, 63)),
                          rand_live());
            end
        end
    endtask

    initial begin
        int ph;
        int target;
        int w;
        int phase_idle [4];
        phase_idle = '{0, 85, 6, 30};
        tracker = new();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        load_start_offset(t_ofs'(START_MAX));

        // directed: empty clear, bad mode, reserve paths, refused write,
        // append, eviction with one and with every temp dead
        send_word(MODE_CLEAR, t_temp'(0), '0);
        send_word(MODE_BAD, t_temp'(63), '1);
        send_word(MODE_RESERVE, t_temp'(5), '0);
        send_word(MODE_RESERVE, t_temp'(5), '1);
        send_word(MODE_WRITE, t_temp'(5), '1);
        send_word(MODE_RESERVE, t_temp'(63), '0);
        send_word(MODE_WRITE, t_temp'(0), '1);
        send_word(MODE_WRITE, t_temp'(1), '1);
        send_word(MODE_WRITE, t_temp'(2), ~t_live'(1));
        send_word(MODE_WRITE, t_temp'(0), '0);
        send_word(MODE_RESERVE, t_temp'(63), '1);
        send_word(MODE_CLEAR, t_temp'(63), '1);
        send_word(MODE_WRITE, t_temp'(1), '0);
        send_word(MODE_BAD, t_temp'(0), '0);
        send_word(MODE_WRITE, t_temp'(62), {1'b1, {(LIVE_W - 2){1'b0}}, 1'b1});
        send_word(MODE_WRITE, t_temp'(30), '0);
        send_word(MODE_CLEAR, t_temp'(0), '0);

        // random phases, each with its own pacing and start offset;
        // the first opens by packing the frame to the last slot
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: load_start_offset(t_ofs'(START_MIN));
                1: load_start_offset(t_ofs'(0));
                default: load_start_offset(t_ofs'($urandom_range(0, 4095)));
            endcase
            idle_pct = phase_idle[ph];
            burst_left = 0;
            if (ph == 0) run_episode(1'b1);
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target) run_episode(1'b0);
        end

        // wind down: wait for the last results, bounded
        start <= 1'b0;
        for (w = 0; w < 1000 && tracker.pending.size() != 0; w++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.pending.size() != 0) begin
            $display("%0t: %0d predicted words never came back", $time,
                     tracker.pending.size());
            tracker.errors += tracker.pending.size();
        end

        $display("run covered %0d requests over 4 pacing phases and %0d start offsets",
                 words_sent, offsets_applied);
        $display("by status: own %0d, evicted %0d, appended %0d, fixed %0d, full %0d, %s",
                 tracker.status_seen[ST_OWN], tracker.status_seen[ST_EVICTED],
                 tracker.status_seen[ST_APPENDED], tracker.status_seen[ST_FIXED],
                 tracker.status_seen[ST_FULL],
                 $sformatf("cleared %0d, refused %0d", tracker.status_seen[ST_RESET_DONE],
                           tracker.status_seen[ST_ERROR]));
        if (tracker.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #(20_000_000);
        $display("%0t: timed out", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule
